[hdl/atft_pkg.sv]
// Shared types, constants and the month length table for the alarm time block.
// No dependencies; used by every module under hdl.
package atft_pkg;

  // Calendar constants
  localparam logic [16:0] SecPerDay   = 17'd86400;
  localparam logic [11:0] SecPerHour  = 12'd3600;
  localparam logic [5:0]  SecPerMin   = 6'd60;
  localparam logic [4:0]  HoursPerDay = 5'd24;
  localparam logic [4:0]  LimitReset  = 5'd10;
  localparam logic [4:0]  LongMonth   = 5'd31;

  // Reciprocals for the constant divisions. The low zero bits of each divisor
  // are shifted off first; each constant is exact over its input range.
  // t / 86400 = (t >> 7) / 675,   25-bit operand
  localparam int unsigned DayPre   = 7;
  localparam int unsigned DayShift = 35;
  localparam logic [25:0] DayRecip = 26'd50903317;
  // r / 3600 = (r >> 4) / 225,    13-bit operand
  localparam int unsigned HourPre   = 4;
  localparam int unsigned HourShift = 21;
  localparam logic [13:0] HourRecip = 14'd9321;
  // r / 60 = (r >> 2) / 15,       10-bit operand
  localparam int unsigned MinPre   = 2;
  localparam int unsigned MinShift = 14;
  localparam logic [10:0] MinRecip = 11'd1093;

  // Register map
  typedef enum logic [0:0] {
    REG_RESET_DAY_LIMIT = 1'b0
  } reg_idx_t;

  localparam logic [4:0] MonthLenCommon [12] =
    '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
  localparam logic [4:0] MonthLenLeap [12] =
    '{5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  // Current calendar time carried along with an item
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } now_t;

  // Per-item flags
  typedef struct packed {
    logic zero;     // timeout was zero: no alarm
    logic rst_req;  // reset request, already qualified by nonzero timeout
  } ctl_t;

  // Timeout split into calendar units, plus the current time
  typedef struct packed {
    ctl_t        ctl;
    now_t        now;
    logic [15:0] days;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
  } split_t;

  // One result item
  typedef struct packed {
    logic       alarm_enable;
    logic [4:0] alarm_hours;
    logic [5:0] alarm_minutes;
    logic [5:0] alarm_seconds;
    logic [7:0] alarm_day;
    logic       reset_request;
  } result_t;

  // Days in a month; leap when year mod 4 is 0, bad month codes count as 31
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [6:0] yr);
    logic [3:0] idx;
    idx = mon - 4'd1;
    if (mon < 4'd1 || mon > 4'd12) begin
      return LongMonth;
    end else if (yr[1:0] == 2'b00) begin
      return MonthLenLeap[idx];
    end else begin
      return MonthLenCommon[idx];
    end
  endfunction

endpackage

[hdl/atft_cfg.sv]
// Configuration register file on an APB-style port: reset day limit.
// Depends on atft_pkg.
module atft_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  reset_day_limit
);

  logic [4:0] limit_r;
  logic [4:0] limit_nxt;
  logic       hit;

  // Register index sits above the byte offset
  assign hit = (paddr[2] == atft_pkg::REG_RESET_DAY_LIMIT);

  // Write on the access phase
  always_comb begin
    limit_nxt = limit_r;
    if (psel && penable && pwrite && hit) begin
      limit_nxt = pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= atft_pkg::LimitReset;
    end else begin
      limit_r <= limit_nxt;
    end
  end

  // Read back
  assign prdata          = hit ? {27'd0, limit_r} : 32'd0;
  assign pready          = 1'b1;
  assign reset_day_limit = limit_r;

endmodule

[hdl/atft_split.sv]
// Splits the timeout into days, hours, minutes and seconds over six stages,
// alternating reciprocal multiply and remainder. Depends on atft_pkg.
module atft_split (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [31:0]         timeout,
  input  atft_pkg::now_t      now,
  input  logic [4:0]          limit,
  output logic                vld,
  output atft_pkg::split_t    split
);

  // Stage valids
  logic [6:0] v_r;

  // Stage 0: input register
  logic [31:0]        t0_r;
  atft_pkg::now_t     now0_r;
  atft_pkg::ctl_t     ctl0_r;
  atft_pkg::ctl_t     ctl0_nxt;
  // Stage 1: day quotient
  logic [31:0]        t1_r;
  logic [15:0]        qd1_r;
  atft_pkg::now_t     now1_r;
  atft_pkg::ctl_t     ctl1_r;
  // Stage 2: day remainder
  logic [15:0]        qd2_r;
  logic [16:0]        rem2_r;
  atft_pkg::now_t     now2_r;
  atft_pkg::ctl_t     ctl2_r;
  // Stage 3: hour quotient
  logic [15:0]        qd3_r;
  logic [16:0]        rem3_r;
  logic [4:0]         qh3_r;
  atft_pkg::now_t     now3_r;
  atft_pkg::ctl_t     ctl3_r;
  // Stage 4: hour remainder
  logic [15:0]        qd4_r;
  logic [4:0]         qh4_r;
  logic [11:0]        rem4_r;
  atft_pkg::now_t     now4_r;
  atft_pkg::ctl_t     ctl4_r;
  // Stage 5: minute quotient
  logic [15:0]        qd5_r;
  logic [4:0]         qh5_r;
  logic [11:0]        rem5_r;
  logic [5:0]         qm5_r;
  atft_pkg::now_t     now5_r;
  atft_pkg::ctl_t     ctl5_r;
  // Stage 6: seconds
  atft_pkg::split_t   s6_r;
  atft_pkg::split_t   s6_nxt;

  logic [50:0] day_prod;
  logic [31:0] day_back;
  logic [16:0] rem2_nxt;
  logic [26:0] hour_prod;
  logic [16:0] hour_back;
  logic [11:0] rem4_nxt;
  logic [20:0] min_prod;
  logic [11:0] min_back;
  logic [5:0]  sec_nxt;

  // Item flags at capture
  always_comb begin
    ctl0_nxt.zero    = (timeout == 32'd0);
    ctl0_nxt.rst_req = (timeout != 32'd0) && (now.date >= limit);
  end

  // Arithmetic between stages
  assign day_prod  = 51'(t0_r[31:atft_pkg::DayPre]) * 51'(atft_pkg::DayRecip);
  assign day_back  = 32'(qd1_r) * 32'(atft_pkg::SecPerDay);
  assign rem2_nxt  = 17'(t1_r - day_back);
  assign hour_prod = 27'(rem2_r[16:atft_pkg::HourPre]) * 27'(atft_pkg::HourRecip);
  assign hour_back = 17'(qh3_r) * 17'(atft_pkg::SecPerHour);
  assign rem4_nxt  = 12'(rem3_r - hour_back);
  assign min_prod  = 21'(rem4_r[11:atft_pkg::MinPre]) * 21'(atft_pkg::MinRecip);
  assign min_back  = 12'(qm5_r) * 12'(atft_pkg::SecPerMin);
  assign sec_nxt   = 6'(rem5_r - min_back);

  always_comb begin
    s6_nxt.ctl     = ctl5_r;
    s6_nxt.now     = now5_r;
    s6_nxt.days    = qd5_r;
    s6_nxt.hours   = qh5_r;
    s6_nxt.minutes = qm5_r;
    s6_nxt.seconds = sec_nxt;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:0], in_vld};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      t0_r   <= timeout;
      now0_r <= now;
      ctl0_r <= ctl0_nxt;

      t1_r   <= t0_r;
      qd1_r  <= day_prod[atft_pkg::DayShift +: 16];
      now1_r <= now0_r;
      ctl1_r <= ctl0_r;

      qd2_r  <= qd1_r;
      rem2_r <= rem2_nxt;
      now2_r <= now1_r;
      ctl2_r <= ctl1_r;

      qd3_r  <= qd2_r;
      rem3_r <= rem2_r;
      qh3_r  <= hour_prod[atft_pkg::HourShift +: 5];
      now3_r <= now2_r;
      ctl3_r <= ctl2_r;

      qd4_r  <= qd3_r;
      qh4_r  <= qh3_r;
      rem4_r <= rem4_nxt;
      now4_r <= now3_r;
      ctl4_r <= ctl3_r;

      qd5_r  <= qd4_r;
      qh5_r  <= qh4_r;
      rem5_r <= rem4_r;
      qm5_r  <= min_prod[atft_pkg::MinShift +: 6];
      now5_r <= now4_r;
      ctl5_r <= ctl4_r;

      s6_r   <= s6_nxt;
    end
  end

  assign vld   = v_r[6];
  assign split = s6_r;

endmodule

[hdl/atft_merge.sv]
// Adds the split timeout to the current time with carries, wraps the day once
// past the month end and holds the result register. Depends on atft_pkg.
module atft_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  atft_pkg::split_t   split,
  output logic               out_vld,
  output atft_pkg::result_t  res
);

  // Reduce a sum below 128 modulo 60: {carry, remainder}
  function automatic logic [7:0] wrap60(input logic [6:0] v);
    logic [6:0] r;
    logic [1:0] c;
    if (v >= 7'd120) begin
      r = v - 7'd120;
      c = 2'd2;
    end else if (v >= 7'd60) begin
      r = v - 7'd60;
      c = 2'd1;
    end else begin
      r = v;
      c = 2'd0;
    end
    return {c, r[5:0]};
  endfunction

  // Reduce a sum below 64 modulo 24: {carry, remainder}
  function automatic logic [6:0] wrap24(input logic [5:0] v);
    logic [5:0] r;
    logic [1:0] c;
    if (v >= 6'd48) begin
      r = v - 6'd48;
      c = 2'd2;
    end else if (v >= 6'(atft_pkg::HoursPerDay)) begin
      r = v - 6'(atft_pkg::HoursPerDay);
      c = 2'd1;
    end else begin
      r = v;
      c = 2'd0;
    end
    return {c, r[4:0]};
  endfunction

  // Stage m1: seconds and minutes with carry
  logic               v1_r;
  atft_pkg::ctl_t     ctl1_r;
  atft_pkg::now_t     now1_r;
  logic [15:0]        days1_r;
  logic [4:0]         hrs1_r;
  logic [5:0]         sec1_r;
  logic [5:0]         min1_r;
  logic [1:0]         cm1_r;
  // Stage m2: hours and days with carry, month length
  logic               v2_r;
  atft_pkg::ctl_t     ctl2_r;
  logic [5:0]         sec2_r;
  logic [5:0]         min2_r;
  logic [4:0]         hrs2_r;
  logic [15:0]        day2_r;
  logic [4:0]         len2_r;
  // Result register
  logic               out_vld_r;
  atft_pkg::result_t  res_r;
  atft_pkg::result_t  res_nxt;

  logic [6:0]  sec_sum;
  logic [7:0]  sec_w;
  logic [6:0]  min_sum;
  logic [7:0]  min_w;
  logic [5:0]  hr_sum;
  logic [6:0]  hr_w;
  logic [15:0] day_sum;
  logic [15:0] day_wrap;

  // m1 logic
  assign sec_sum = 7'(split.now.seconds) + 7'(split.seconds);
  assign sec_w   = wrap60(sec_sum);
  assign min_sum = 7'(split.now.minutes) + 7'(split.minutes) + 7'(sec_w[7:6]);
  assign min_w   = wrap60(min_sum);

  // m2 logic
  assign hr_sum  = 6'(now1_r.hours) + 6'(hrs1_r) + 6'(cm1_r);
  assign hr_w    = wrap24(hr_sum);
  assign day_sum = 16'(now1_r.date) + days1_r + 16'(hr_w[6:5]);

  // Single month wrap and zero-timeout masking
  assign day_wrap = (day2_r > 16'(len2_r)) ? (day2_r - 16'(len2_r)) : day2_r;

  always_comb begin
    if (ctl2_r.zero) begin
      res_nxt = '0;
    end else begin
      res_nxt.alarm_enable  = 1'b1;
      res_nxt.alarm_hours   = hrs2_r;
      res_nxt.alarm_minutes = min2_r;
      res_nxt.alarm_seconds = sec2_r;
      res_nxt.alarm_day     = day_wrap[7:0];
      res_nxt.reset_request = ctl2_r.rst_req;
    end
  end

  // Valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      out_vld_r <= v2_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r  <= split.ctl;
      now1_r  <= split.now;
      days1_r <= split.days;
      hrs1_r  <= split.hours;
      sec1_r  <= sec_w[5:0];
      min1_r  <= min_w[5:0];
      cm1_r   <= min_w[7:6];

      ctl2_r  <= ctl1_r;
      sec2_r  <= sec1_r;
      min2_r  <= min1_r;
      hrs2_r  <= hr_w[4:0];
      day2_r  <= day_sum;
      len2_r  <= atft_pkg::month_len(now1_r.month, now1_r.year);

      res_r   <= res_nxt;
    end
  end

  assign out_vld = out_vld_r;
  assign res     = res_r;

endmodule

[hdl/alarm_time_from_timeout.sv]
// Alarm time from a timeout: each item gives a timeout in seconds and the
// current calendar time, and yields one result with the alarm time of day and
// the alarm day (wrapped once past the end of the current month, leap years
// every fourth year), or all zeros when the timeout is zero. reset_request is
// set when the timeout is nonzero and the current date has reached the
// reset day limit register (APB, byte address 0, reset value 10). The block
// is a ten-stage pipeline: the split stages, the merge stages and the result
// register, and one item is taken every cycle while results are drained. The
// whole pipeline holds when a result waits at the output; the depth comes
// from the three constant divisions, each a reciprocal multiply followed by
// a remainder stage, plus the input register and the carry and month wrap stages.
// Depends on atft_pkg, atft_cfg, atft_split and atft_merge.
module alarm_time_from_timeout (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_timeout_seconds,
  input  logic [4:0]  in_now_hours,
  input  logic [5:0]  in_now_minutes,
  input  logic [5:0]  in_now_seconds,
  input  logic [4:0]  in_now_date,
  input  logic [3:0]  in_now_month,
  input  logic [6:0]  in_now_year,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_alarm_enable,
  output logic [4:0]  out_alarm_hours,
  output logic [5:0]  out_alarm_minutes,
  output logic [5:0]  out_alarm_seconds,
  output logic [7:0]  out_alarm_day,
  output logic        out_reset_request,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               adv;
  logic [4:0]         limit;
  atft_pkg::now_t     now;
  logic               split_vld;
  atft_pkg::split_t   split;
  atft_pkg::result_t  res;

  // Pipeline moves whenever the result register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    now.hours   = in_now_hours;
    now.minutes = in_now_minutes;
    now.seconds = in_now_seconds;
    now.date    = in_now_date;
    now.month   = in_now_month;
    now.year    = in_now_year;
  end

  atft_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .reset_day_limit (limit)
  );

  atft_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .timeout (in_timeout_seconds),
    .now     (now),
    .limit   (limit),
    .vld     (split_vld),
    .split   (split)
  );

  atft_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (split_vld),
    .split   (split),
    .out_vld (out_valid),
    .res     (res)
  );

  // Result fields
  assign out_alarm_enable  = res.alarm_enable;
  assign out_alarm_hours   = res.alarm_hours;
  assign out_alarm_minutes = res.alarm_minutes;
  assign out_alarm_seconds = res.alarm_seconds;
  assign out_alarm_day     = res.alarm_day;
  assign out_reset_request = res.reset_request;

`ifndef ASSERT_OFF
  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A disabled alarm carries no reset request, no alarm day and no alarm hours
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_alarm_enable) |->
      (!out_reset_request && out_alarm_day == 8'd0 && out_alarm_hours == 5'd0))
    else $error("zero-timeout result has nonzero fields");

  // Carries keep the time of day in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_alarm_hours < 5'd24 && out_alarm_minutes < 6'd60 && out_alarm_seconds < 6'd60))
    else $error("alarm time of day out of range");
`endif

endmodule

[test/tb_alarm_time_from_timeout.sv]
// Self-checking testbench for alarm_time_from_timeout: directed calendar corners,
// then random traffic over several day limit settings, mostly with random idling on both sides.
// Depends on atft_pkg and the RTL under hdl; reads no files.
module tb_alarm_time_from_timeout;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned DaySecs     = 86400;
  localparam int unsigned HourSecs    = 3600;
  localparam int unsigned MinSecs     = 60;
  localparam int unsigned DayHours    = 24;
  localparam logic [4:0]  LimitAtReset = 5'd10;

  // One input item
  typedef struct packed {
    logic [31:0] timeout;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [4:0]  date;
    logic [3:0]  month;
    logic [6:0]  year;
  } alarm_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_timeout_seconds;
  logic [4:0]  in_now_hours;
  logic [5:0]  in_now_minutes;
  logic [5:0]  in_now_seconds;
  logic [4:0]  in_now_date;
  logic [3:0]  in_now_month;
  logic [6:0]  in_now_year;
  logic        out_valid;
  logic        out_ready;
  logic        out_alarm_enable;
  logic [4:0]  out_alarm_hours;
  logic [5:0]  out_alarm_minutes;
  logic [5:0]  out_alarm_seconds;
  logic [7:0]  out_alarm_day;
  logic        out_reset_request;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  atft_pkg::result_t alarm_expect_q[$];
  logic [4:0]        day_limit;
  int unsigned       err_count;
  int unsigned       result_count;
  int unsigned       cycle_count;
  bit                in_idle_on;
  bit                out_idle_on;

  alarm_time_from_timeout dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_timeout_seconds(in_timeout_seconds),
    .in_now_hours      (in_now_hours),
    .in_now_minutes    (in_now_minutes),
    .in_now_seconds    (in_now_seconds),
    .in_now_date       (in_now_date),
    .in_now_month      (in_now_month),
    .in_now_year       (in_now_year),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_alarm_enable  (out_alarm_enable),
    .out_alarm_hours   (out_alarm_hours),
    .out_alarm_minutes (out_alarm_minutes),
    .out_alarm_seconds (out_alarm_seconds),
    .out_alarm_day     (out_alarm_day),
    .out_reset_request (out_reset_request),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= !(out_idle_on && $urandom_range(99) < 34);
    end
  end

  // Days in a month; bad month codes count as long months
  function automatic int unsigned month_days(logic [3:0] mon, logic [6:0] yr);
    case (mon)
      4'd2: begin
        return (yr[1:0] == 2'b00) ? 29 : 28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Alarm time of day and day of month for one item
  function automatic atft_pkg::result_t predict_alarm(alarm_req_t r, logic [4:0] limit);
    atft_pkg::result_t res;
    int unsigned rest, days, hrs, mins, secs, len;
    res = '0;
    if (r.timeout == 32'd0) begin
      return res;
    end
    rest = r.timeout;
    days = r.date + rest / DaySecs;
    rest = rest % DaySecs;
    hrs  = r.hours + rest / HourSecs;
    rest = rest % HourSecs;
    mins = r.minutes + rest / MinSecs;
    secs = r.seconds + rest % MinSecs;
    mins = mins + secs / MinSecs;
    secs = secs % MinSecs;
    hrs  = hrs + mins / MinSecs;
    mins = mins % MinSecs;
    days = days + hrs / DayHours;
    hrs  = hrs % DayHours;
    len  = month_days(r.month, r.year);
    if (days > len) begin
      days = days - len;
    end
    res.alarm_enable  = 1'b1;
    res.alarm_hours   = hrs[4:0];
    res.alarm_minutes = mins[5:0];
    res.alarm_seconds = secs[5:0];
    res.alarm_day     = days[7:0];
    res.reset_request = (r.date >= limit);
    return res;
  endfunction

  function automatic alarm_req_t mk_req(logic [31:0] t, logic [4:0] h, logic [5:0] m,
                                        logic [5:0] s, logic [4:0] d, logic [3:0] mo,
                                        logic [6:0] y);
    alarm_req_t r;
    r = '{t, h, m, s, d, mo, y};
    return r;
  endfunction

  // Mostly legal calendar values, with the odd full-width field
  function automatic alarm_req_t random_req();
    alarm_req_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.timeout = 32'd0;
    end else if (pick < 45) begin
      r.timeout = $urandom_range(200000, 1);
    end else if (pick < 75) begin
      r.timeout = $urandom_range(40 * DaySecs, 1);
    end else begin
      r.timeout = $urandom;
    end
    r.hours   = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom);
    r.minutes = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom);
    r.seconds = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom);
    // bias the date toward month ends so the wrap gets exercised
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.date = 5'($urandom_range(31, 26));
    end else if (pick < 90) begin
      r.date = 5'($urandom_range(31, 1));
    end else begin
      r.date = 5'($urandom);
    end
    r.month = ($urandom_range(99) < 85) ? 4'($urandom_range(12, 1)) : 4'($urandom);
    r.year  = ($urandom_range(99) < 85) ? 7'($urandom_range(99)) : 7'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned exp);
    if (got != exp) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_count, name, got, exp));
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (alarm_expect_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                  result_count));
      end else begin
        atft_pkg::result_t exp;
        exp = alarm_expect_q.pop_front();
        check_field("alarm_enable", out_alarm_enable, exp.alarm_enable);
        check_field("alarm_hours", out_alarm_hours, exp.alarm_hours);
        check_field("alarm_minutes", out_alarm_minutes, exp.alarm_minutes);
        check_field("alarm_seconds", out_alarm_seconds, exp.alarm_seconds);
        check_field("alarm_day", out_alarm_day, exp.alarm_day);
        check_field("reset_request", out_reset_request, exp.reset_request);
      end
      result_count++;
    end
  end

  // Send one item, with an optional idle gap in front of it
  task automatic send_alarm_request(alarm_req_t r);
    int unsigned gap;
    gap = 0;
    // each cycle idles with the same odds, so the gap length is geometric
    while (in_idle_on && $urandom_range(99) < 34) begin
      gap++;
    end
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_timeout_seconds <= r.timeout;
    in_now_hours       <= r.hours;
    in_now_minutes     <= r.minutes;
    in_now_seconds     <= r.seconds;
    in_now_date        <= r.date;
    in_now_month       <= r.month;
    in_now_year        <= r.year;
    forever begin
      @(posedge clk);
      if (in_ready) begin
        break;
      end
    end
    alarm_expect_q.push_back(predict_alarm(r, day_limit));
  endtask

  // Stop sending and wait for every outstanding result, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (alarm_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // APB read of the day limit, compared with the shadow copy
  task automatic read_day_limit();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {atft_pkg::REG_RESET_DAY_LIMIT, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) begin
        break;
      end
    end
    if (prdata != {27'd0, day_limit}) begin
      report_mismatch($sformatf("day limit reads %0d expected %0d", prdata, day_limit));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write of the day limit; only called with the block idle
  task automatic write_day_limit(logic [4:0] limit);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {atft_pkg::REG_RESET_DAY_LIMIT, 2'b00};
    pwdata  <= {27'd0, limit};
    @(negedge clk);
    penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (pready) begin
        break;
      end
    end
    day_limit = limit;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_day_limit();
  endtask

  // Field extremes, carries and out-of-range time fields at the reset limit
  task automatic test_field_extremes();
    read_day_limit();
    send_alarm_request(mk_req(32'd0, 5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 7'd99));
    send_alarm_request(mk_req(32'hFFFF_FFFF, 5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 7'd99));
    send_alarm_request(mk_req(32'hFFFF_FFFF, 5'd0, 6'd0, 6'd0, 5'd1, 4'd1, 7'd0));
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd31, 4'd12, 7'd99));
    send_alarm_request(mk_req(32'd1, 5'd31, 6'd63, 6'd63, 5'd15, 4'd6, 7'd127));
    send_alarm_request(mk_req(32'd59, 5'd0, 6'd0, 6'd1, 5'd9, 4'd3, 7'd1));
    send_alarm_request(mk_req(32'd60, 5'd0, 6'd59, 6'd0, 5'd10, 4'd3, 7'd1));
    send_alarm_request(mk_req(32'd3599, 5'd22, 6'd0, 6'd1, 5'd5, 4'd7, 7'd2));
    send_alarm_request(mk_req(32'd3600, 5'd23, 6'd0, 6'd0, 5'd5, 4'd7, 7'd2));
    send_alarm_request(mk_req(32'd86399, 5'd0, 6'd0, 6'd1, 5'd30, 4'd9, 7'd3));
    send_alarm_request(mk_req(32'd86400, 5'd12, 6'd30, 6'd30, 5'd0, 4'd9, 7'd3));
  endtask

  // Month wrap: leap and common February, bad month codes, odd years
  task automatic test_month_wrap();
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd28, 4'd2, 7'd1));
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd28, 4'd2, 7'd4));
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd29, 4'd2, 7'd4));
    send_alarm_request(mk_req(32'd86400, 5'd8, 6'd0, 6'd0, 5'd30, 4'd4, 7'd50));
    send_alarm_request(mk_req(32'd86400, 5'd8, 6'd0, 6'd0, 5'd31, 4'd0, 7'd50));
    send_alarm_request(mk_req(32'd86400, 5'd8, 6'd0, 6'd0, 5'd31, 4'd13, 7'd50));
    send_alarm_request(mk_req(32'd86400, 5'd8, 6'd0, 6'd0, 5'd31, 4'd15, 7'd50));
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd28, 4'd2, 7'd100));
    send_alarm_request(mk_req(32'd1, 5'd23, 6'd59, 6'd59, 5'd28, 4'd2, 7'd127));
    send_alarm_request(mk_req(32'd2592000, 5'd0, 6'd0, 6'd0, 5'd31, 4'd11, 7'd8));
  endtask

  // Day limit extremes: zero, one and the top value
  task automatic test_day_limit_extremes();
    wait_idle();
    write_day_limit(5'd0);
    send_alarm_request(mk_req(32'd5, 5'd1, 6'd2, 6'd3, 5'd0, 4'd5, 7'd21));
    send_alarm_request(mk_req(32'd0, 5'd1, 6'd2, 6'd3, 5'd0, 4'd5, 7'd21));
    wait_idle();
    write_day_limit(5'd31);
    send_alarm_request(mk_req(32'd5, 5'd1, 6'd2, 6'd3, 5'd30, 4'd5, 7'd21));
    send_alarm_request(mk_req(32'd5, 5'd1, 6'd2, 6'd3, 5'd31, 4'd5, 7'd21));
    wait_idle();
    write_day_limit(5'd1);
    send_alarm_request(mk_req(32'd5, 5'd1, 6'd2, 6'd3, 5'd1, 4'd5, 7'd21));
    wait_idle();
  endtask

  // Random items under one day limit, optionally pausing halfway until drained
  task automatic test_random_traffic(int unsigned n, logic [4:0] limit, bit idling,
                                     bit pause_mid);
    write_day_limit(limit);
    in_idle_on  = idling;
    out_idle_on = idling;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        wait_idle();
      end
      send_alarm_request(random_req());
    end
    wait_idle();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_timeout_seconds = '0;
    in_now_hours       = '0;
    in_now_minutes     = '0;
    in_now_seconds     = '0;
    in_now_date        = '0;
    in_now_month       = '0;
    in_now_year        = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    day_limit          = LimitAtReset;
    err_count          = 0;
    result_count       = 0;
    in_idle_on         = 1'b1;
    out_idle_on        = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_month_wrap();
    test_day_limit_extremes();
    // long stretch with no idling on either side
    test_random_traffic(100, 5'd10, 1'b0, 1'b0);
    test_random_traffic(100, 5'($urandom_range(31)), 1'b1, 1'b1);
    test_random_traffic(100, 5'd0, 1'b1, 1'b0);
    test_random_traffic(100, 5'd31, 1'b1, 1'b0);
    test_random_traffic(100, 5'($urandom_range(31)), 1'b1, 1'b0);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
